/* sv/mcs_pkg.sv */
// Shared types and constants for the minimax centre select block.
// Used by mcs_dist_store and minimax_center_select; depends on nothing.
package mcs_pkg;

  // Widths fixed by the item format
  localparam int POINT_W    = 6;
  localparam int DIST_IN_W  = 32;
  localparam int RADIUS_W   = 32;
  localparam int FUNC_W     = 2;

  // Parameter defaults
  localparam int MAX_POINTS_DEF  = 64;
  localparam int MAX_MEMBERS_DEF = 64;
  localparam int DIST_WIDTH_DEF  = 32;

  // Request kinds
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  // Distance store write port
  typedef struct packed {
    logic               en;
    logic [POINT_W-1:0] a;
    logic [POINT_W-1:0] b;
  } dist_wr_t;

  // Distance store read address pair
  typedef struct packed {
    logic [POINT_W-1:0] a;
    logic [POINT_W-1:0] b;
  } dist_rd_t;

endpackage

/* sv/mcs_dist_store.sv */
// Symmetric pairwise distance store with one write and one registered read port.
// Depends on mcs_pkg for the port structs and point width.
module mcs_dist_store #(
  parameter int MAX_POINTS = mcs_pkg::MAX_POINTS_DEF,
  parameter int DIST_WIDTH = mcs_pkg::DIST_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  mcs_pkg::dist_wr_t     wr_i,
  input  logic [DIST_WIDTH-1:0] wdata_i,
  input  mcs_pkg::dist_rd_t     rd_i,
  output logic [DIST_WIDTH-1:0] rdata_o
);

  localparam int EffPts = (MAX_POINTS < (1 << mcs_pkg::POINT_W)) ?
                          MAX_POINTS : (1 << mcs_pkg::POINT_W);
  localparam int Aw     = $clog2(EffPts);
  localparam int Depth  = 1 << (2 * Aw);

  logic [DIST_WIDTH-1:0] mem_q [Depth];
  logic [2*Aw-1:0]       waddr;
  logic [2*Aw-1:0]       raddr;

  // Keep one copy per unordered pair: smaller index in the upper half
  always_comb begin
    if (wr_i.a <= wr_i.b) begin
      waddr = {wr_i.a[Aw-1:0], wr_i.b[Aw-1:0]};
    end else begin
      waddr = {wr_i.b[Aw-1:0], wr_i.a[Aw-1:0]};
    end
    if (rd_i.a <= rd_i.b) begin
      raddr = {rd_i.a[Aw-1:0], rd_i.b[Aw-1:0]};
    end else begin
      raddr = {rd_i.b[Aw-1:0], rd_i.a[Aw-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[waddr] <= wdata_i;
    end
    rdata_o <= mem_q[raddr];
  end

endmodule

/* sv/minimax_center_select.sv */
// Minimax centre select: top level with member list, sequencer and result register.
// Depends on mcs_pkg and mcs_dist_store.
//
// Usage
//   Requests arrive on the s_axis channel; tuser carries the request kind
//   (load distance, add member, compute). Load writes one distance for an
//   unordered point pair; add appends a point to the member list; compute
//   takes every member as candidate centre, finds its largest distance to
//   any member and returns the candidate with the smallest such radius
//   (earliest member on a tie), then empties the member list.
//   Only compute gives a result, on the m_axis channel.
// Throughput
//   Loads and adds are taken back to back while idle. A compute walks the
//   member list once per candidate with the single shared compare unit,
//   one distance read per cycle through the registered member-list and
//   distance-store read ports. s_axis_tready is low for the whole
//   compute.
// Reset
//   Clears member count, overflow flag, sequencer, read-pipeline valids,
//   found flag and output valid. The distance store and member list hold no
//   reset value; read only pairs that were loaded.
// Stalls
//   A finished result waits in the output register; loads and adds are still
//   taken meanwhile. A further compute holds its result until the previous
//   one has been taken.
module minimax_center_select #(
  parameter int MAX_POINTS  = mcs_pkg::MAX_POINTS_DEF,
  parameter int MAX_MEMBERS = mcs_pkg::MAX_MEMBERS_DEF,
  parameter int DIST_WIDTH  = mcs_pkg::DIST_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [5:0] row_point, [11:6] col_point, [43:12] dist_value,
  // [49:44] member_point, [55:50] zero
  input  logic [55:0] s_axis_tdata_i,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser_i,
  // Result channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] radius, [37:32] best_point, [38] found, [39] overflow
  output logic [39:0] m_axis_tdata_o
);

  localparam int MAw = $clog2(MAX_MEMBERS);
  localparam int Cw  = $clog2(MAX_MEMBERS + 1);
  localparam int Pw  = mcs_pkg::POINT_W;

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;  // take requests
  localparam logic [2:0] ST_CRD  = 3'd1;  // read candidate from member list
  localparam logic [2:0] ST_CWT  = 3'd2;  // latch candidate
  localparam logic [2:0] ST_SCAN = 3'd3;  // stream members, track radius
  localparam logic [2:0] ST_EVAL = 3'd4;  // compare radius with best
  localparam logic [2:0] ST_DONE = 3'd5;  // hand result to output register

  // Request fields
  logic [mcs_pkg::FUNC_W-1:0]    req_func;
  logic [Pw-1:0]                 req_row;
  logic [Pw-1:0]                 req_col;
  logic [mcs_pkg::DIST_IN_W-1:0] req_dist;
  logic [Pw-1:0]                 req_member;
  logic                          req_acc;

  assign req_func   = s_axis_tuser_i;
  assign req_row    = s_axis_tdata_i[5:0];
  assign req_col    = s_axis_tdata_i[11:6];
  assign req_dist   = s_axis_tdata_i[43:12];
  assign req_member = s_axis_tdata_i[49:44];
  assign req_acc    = s_axis_tvalid_i && s_axis_tready_o;

  // Control state
  logic [2:0]    st_q, st_d;
  logic [Cw-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [Cw-1:0] n_q, n_d;
  logic [Cw-1:0] i_q, i_d;
  logic [Cw-1:0] j_q, j_d;
  logic          v1_q, v1_d;
  logic          v2_q, v2_d;
  logic          have_q, have_d;
  logic          out_valid_q, out_valid_d;

  // Datapath registers
  logic [Pw-1:0]         cand_q, cand_d;
  logic [DIST_WIDTH-1:0] radius_q, radius_d;
  logic [DIST_WIDTH-1:0] best_r_q, best_r_d;
  logic [Pw-1:0]         best_p_q, best_p_d;
  logic [39:0]           out_data_q, out_data_d;

  // Member list memory
  logic [Pw-1:0]  member_mem [MAX_MEMBERS];
  logic [Pw-1:0]  mem_rdata_q;
  logic [MAw-1:0] mem_raddr;
  logic           mem_we;

  // Distance store ports
  mcs_pkg::dist_wr_t     dist_wr;
  mcs_pkg::dist_rd_t     dist_rd;
  logic [DIST_WIDTH-1:0] dist_rdata;

  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Load writes one canonical entry per pair; out-of-range points are dropped
  always_comb begin
    dist_wr.en = req_acc && (req_func == mcs_pkg::FUNC_LOAD) &&
                 (req_row < MAX_POINTS) && (req_col < MAX_POINTS);
    dist_wr.a  = req_row;
    dist_wr.b  = req_col;
    dist_rd.a  = cand_q;
    dist_rd.b  = mem_rdata_q;
  end

  mcs_dist_store #(
    .MAX_POINTS (MAX_POINTS),
    .DIST_WIDTH (DIST_WIDTH)
  ) u_dist (
    .clk_i   (clk_i),
    .wr_i    (dist_wr),
    .wdata_i (DIST_WIDTH'(req_dist)),
    .rd_i    (dist_rd),
    .rdata_o (dist_rdata)
  );

  assign mem_we = req_acc && (req_func == mcs_pkg::FUNC_ADD) &&
                  (req_member < MAX_POINTS) && (count_q < Cw'(MAX_MEMBERS));
  assign mem_raddr = (st_q == ST_CRD) ? i_q[MAw-1:0] : j_q[MAw-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      member_mem[count_q[MAw-1:0]] <= req_member;
    end
    mem_rdata_q <= member_mem[mem_raddr];
  end

  function automatic logic [mcs_pkg::RADIUS_W-1:0] RADIUS_CAST(
    input logic [DIST_WIDTH-1:0] r
  );
    return mcs_pkg::RADIUS_W'(r);
  endfunction

  // Sequencer and shared compare unit
  always_comb begin
    st_d        = st_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    v1_d        = 1'b0;
    v2_d        = v1_q;
    have_d      = have_q;
    cand_d      = cand_q;
    radius_d    = radius_q;
    best_r_d    = best_r_q;
    best_p_d    = best_p_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;

    case (st_q)
      ST_IDLE: begin
        if (req_acc) begin
          case (req_func)
            mcs_pkg::FUNC_ADD: begin
              if (req_member < MAX_POINTS) begin
                if (count_q < Cw'(MAX_MEMBERS)) begin
                  count_d = count_q + Cw'(1);
                end else begin
                  ovf_d = 1'b1;
                end
              end
            end
            mcs_pkg::FUNC_COMPUTE: begin
              n_d      = count_q;
              i_d      = '0;
              have_d   = 1'b0;
              best_r_d = '1;
              best_p_d = '0;
              st_d     = (count_q == '0) ? ST_DONE : ST_CRD;
            end
            default: ;
          endcase
        end
      end
      ST_CRD: begin
        st_d = ST_CWT;
      end
      ST_CWT: begin
        cand_d   = mem_rdata_q;
        j_d      = '0;
        radius_d = '0;
        st_d     = ST_SCAN;
      end
      ST_SCAN: begin
        // Issue one member read per cycle, then drain the two read stages
        if (j_q < n_q) begin
          j_d  = j_q + Cw'(1);
          v1_d = 1'b1;
        end else if (!v1_q && !v2_q) begin
          st_d = ST_EVAL;
        end
        if (v2_q && (dist_rdata > radius_q)) begin
          radius_d = dist_rdata;
        end
      end
      ST_EVAL: begin
        if (!have_q || (radius_q < best_r_q)) begin
          best_r_d = radius_q;
          best_p_d = cand_q;
          have_d   = 1'b1;
        end
        i_d  = i_q + Cw'(1);
        st_d = (i_q + Cw'(1) == n_q) ? ST_DONE : ST_CRD;
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_data_d  = {ovf_q, have_q, best_p_q, RADIUS_CAST(best_r_q)};
          out_valid_d = 1'b1;
          count_d     = '0;
          ovf_d       = 1'b0;
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    i_q        <= i_d;
    j_q        <= j_d;
    cand_q     <= cand_d;
    radius_q   <= radius_d;
    best_r_q   <= best_r_d;
    best_p_q   <= best_p_d;
    out_data_q <= out_data_d;
  end

  // Checks
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (req_func == mcs_pkg::FUNC_COMPUTE)) |=> !s_axis_tready_o)
    else $error("compute request did not make the block busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Cw'(MAX_MEMBERS))
    else $error("member count beyond capacity");

  a_empty_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q[38]) |-> (out_data_q[37:32] == '0))
    else $error("empty result carries a non-zero point");

  a_read_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q))
    else $error("distance stage valid without member stage");

  a_scan_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (st_q == ST_SCAN))
    else $error("member read in flight outside the scan");

endmodule
